FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the queue unit.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at each rising clock edge, off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check prop at each rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/mqufdq_pkg.sv
// Package of the multi-queue deque unit: defaults, codes and the sequencer type.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package mqufdq_pkg;

   localparam int DEF_NUM_QUEUES  = 16;
   localparam int DEF_QUEUE_DEPTH = 8;
   localparam int DEF_TAG_WIDTH   = 16;

   localparam int SEL_W = 4;
   localparam int SEL_N = 2 ** SEL_W;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_TAKE = 1'b1;

   typedef enum logic [1:0] {
      OUT_ADDED   = 2'd0,
      OUT_REFUSED = 2'd1,
      OUT_TAKEN   = 2'd2,
      OUT_EMPTY   = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_RESPOND
   } state_type;

endpackage

FILE: rtl/multi_queue_urgent_front_deque_unit.sv
// Top level of the multi-queue deque unit: sequencer, queue-state memory, result path.
// Depends on mqufdq_pkg, mqufdq_entry_ram and assert_macros.svh.
//
//   channel   ports                 handshake
//   -------   -------------------   ----------------------------------------
//   request   start, req_*          item taken at a rising edge: start && !busy
//   result    rsp_valid, rsp_*      one-cycle strobe, always taken
//
// An item passes a lookup state, which works on the queue's head and length read from
// the queue-state memory, then a respond state, which returns the entry memory read.
// busy is high during the lookup state, so no new item is taken while a lookup runs.
// The result appears in the respond state, which follows the lookup state.
// Synchronous reset clears the per-queue valid bits: every queue reads empty.
// The receiver cannot stall, so no result is ever held back.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_queue_urgent_front_deque_unit
   import mqufdq_pkg::*;
#(
   parameter int NUM_QUEUES  = DEF_NUM_QUEUES,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TAG_WIDTH   = DEF_TAG_WIDTH,
   parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_action,
   input  logic [SEL_W-1:0]     req_queue_select,
   input  logic [TAG_WIDTH-1:0] req_entry_tag,
   input  logic                 req_urgent,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_outcome,
   output logic [TAG_WIDTH-1:0] rsp_taken_tag,
   output logic                 rsp_taken_urgent,
   output logic [CNT_W-1:0]     rsp_queue_count
);

   localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int SUM_W  = PTR_W + 1;
   localparam int SLOTS  = NUM_QUEUES * QUEUE_DEPTH;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int ENT_W  = TAG_WIDTH + 1;

   localparam logic [CNT_W-1:0]  DEPTH_CNT  = CNT_W'(QUEUE_DEPTH);
   localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [SUM_W-1:0]  DEPTH_SUM  = SUM_W'(QUEUE_DEPTH);
   localparam logic [SLOT_W-1:0] DEPTH_SLOT = SLOT_W'(QUEUE_DEPTH);

   state_type state_ff, state_in;

   logic [QIDX_W-1:0] qsel_map [SEL_N];

   logic [CNT_W-1:0] qlen_mem  [NUM_QUEUES];
   logic [PTR_W-1:0] qhead_mem [NUM_QUEUES];
   logic [NUM_QUEUES-1:0] qvalid_ff;

   logic [QIDX_W-1:0]    q_ff;
   logic                 action_ff;
   logic [TAG_WIDTH-1:0] tag_ff;
   logic                 urgent_ff;
   logic [CNT_W-1:0]     qlen_rd_ff;
   logic [PTR_W-1:0]     qhead_rd_ff;
   logic                 qvalid_rd_ff;

   logic [1:0]       res_outcome_ff;
   logic [CNT_W-1:0] res_count_ff;
   logic             res_taken_ff;

   logic             accept;
   logic             lookup;
   logic [QIDX_W-1:0] q_sel;
   logic [CNT_W-1:0] cur_len;
   logic [PTR_W-1:0] cur_head;
   logic [CNT_W-1:0] new_len;
   logic [PTR_W-1:0] new_head;
   logic [PTR_W-1:0] prev_head;
   logic [SUM_W-1:0] tail_sum;
   logic [PTR_W-1:0] tail_pos;
   logic [PTR_W-1:0] slot_pos;
   logic [SLOT_W-1:0] slot_addr;
   logic             take_ok;
   logic             add_ok;
   logic [1:0]       outcome;
   logic [ENT_W-1:0] ent_rdata;

   for (genvar gi = 0; gi < SEL_N; gi++) begin : g_qsel
      assign qsel_map[gi] = QIDX_W'(gi % NUM_QUEUES);
   end

   assign q_sel = qsel_map[req_queue_select];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      busy      = reset;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            busy     = 1'b1;
            state_in = ST_RESPOND;
         end
         ST_RESPOND: begin
            rsp_valid = 1'b1;
            state_in  = start ? ST_LOOKUP : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign accept = start && !busy;
   assign lookup = (state_ff == ST_LOOKUP);

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff         <= q_sel;
         action_ff    <= req_action;
         tag_ff       <= req_entry_tag;
         urgent_ff    <= req_urgent;
         qlen_rd_ff   <= qlen_mem[q_sel];
         qhead_rd_ff  <= qhead_mem[q_sel];
         qvalid_rd_ff <= qvalid_ff[q_sel];
      end
   end

   always_comb begin
      cur_len   = qvalid_rd_ff ? qlen_rd_ff : '0;
      cur_head  = qvalid_rd_ff ? qhead_rd_ff : '0;
      prev_head = (cur_head == '0) ? LAST_PTR : cur_head - 1'b1;
      tail_sum  = SUM_W'(cur_head) + SUM_W'(cur_len);
      tail_pos  = (tail_sum >= DEPTH_SUM) ? PTR_W'(tail_sum - DEPTH_SUM) : PTR_W'(tail_sum);
      take_ok   = 1'b0;
      add_ok    = 1'b0;
      new_len   = cur_len;
      new_head  = cur_head;
      slot_pos  = cur_head;
      if (action_ff == ACT_TAKE) begin
         if (cur_len == '0) begin
            outcome = OUT_EMPTY;
         end else begin
            outcome  = OUT_TAKEN;
            take_ok  = 1'b1;
            new_len  = cur_len - 1'b1;
            new_head = (cur_head == LAST_PTR) ? '0 : cur_head + 1'b1;
         end
      end else begin
         if (cur_len >= DEPTH_CNT) begin
            outcome = OUT_REFUSED;
         end else begin
            outcome = OUT_ADDED;
            add_ok  = 1'b1;
            new_len = cur_len + 1'b1;
            if (urgent_ff) begin
               new_head = prev_head;
               slot_pos = prev_head;
            end else begin
               slot_pos = tail_pos;
            end
         end
      end
      slot_addr = SLOT_W'(q_ff) * DEPTH_SLOT + SLOT_W'(slot_pos);
   end

   always_ff @(posedge clock) begin
      if (lookup && (take_ok || add_ok)) begin
         qlen_mem[q_ff]  <= new_len;
         qhead_mem[q_ff] <= new_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qvalid_ff <= '0;
      end else if (lookup && (take_ok || add_ok)) begin
         qvalid_ff[q_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup) begin
         res_outcome_ff <= outcome;
         res_count_ff   <= new_len;
         res_taken_ff   <= take_ok;
      end
   end

   mqufdq_entry_ram #(
      .DEPTH  (SLOTS),
      .WIDTH  (ENT_W),
      .ADDR_W (SLOT_W)
   ) u_entry_ram (
      .clock (clock),
      .en    (lookup && (take_ok || add_ok)),
      .we    (add_ok),
      .addr  (slot_addr),
      .wdata ({urgent_ff, tag_ff}),
      .rdata (ent_rdata)
   );

   assign rsp_outcome      = res_outcome_ff;
   assign rsp_queue_count  = res_count_ff;
   assign rsp_taken_tag    = res_taken_ff ? ent_rdata[TAG_WIDTH-1:0] : '0;
   assign rsp_taken_urgent = res_taken_ff ? ent_rdata[TAG_WIDTH] : 1'b0;

   `ASSERT_CLK(a_accept_then_lookup, clock, reset, accept |=> busy, "accept not followed by lookup")
   `ASSERT_CLK(a_lookup_then_result, clock, reset, busy |=> rsp_valid, "lookup without result")
   `ASSERT_CLK(a_count_bound, clock, reset, rsp_valid |-> (rsp_queue_count <= DEPTH_CNT), "count beyond depth")
   `ASSERT_CLK(a_refused_full, clock, reset, (rsp_valid && rsp_outcome == OUT_REFUSED) |-> (rsp_queue_count == DEPTH_CNT), "refused add on queue not full")
   `ASSERT_CLK(a_empty_zero, clock, reset, (rsp_valid && rsp_outcome == OUT_EMPTY) |-> (rsp_queue_count == '0 && rsp_taken_tag == '0), "empty take with data")

endmodule

FILE: rtl/mqufdq_entry_ram.sv
// Single-port entry memory with a registered read, one access per cycle.
// No dependencies; instantiated by the top level.
`timescale 1ns / 1ps

module mqufdq_entry_ram #(
   parameter int DEPTH  = 128,
   parameter int WIDTH  = 17,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              en,
   input  logic              we,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule
